@@ src/aho_pkg.sv @@
`default_nettype none

package aho_pkg;

   // Sine table geometry. The table holds one period; only the first quadrant
   // plus its end point is stored, the rest follows by symmetry.
   localparam int SINE_TABLE_SIZE = 4096;
   localparam int SINE_AW         = $clog2(SINE_TABLE_SIZE);
   localparam int QUARTER_SIZE    = SINE_TABLE_SIZE / 4;
   localparam int QUARTER_AW      = $clog2(QUARTER_SIZE + 1);

   // Bit of the Q7.49 phase product just below the integer part.
   localparam int FRAC_MSB = 48;

   localparam longint PI_Q30 = 64'sd3373259426;

   // Command queue between the front and back parts.
   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);

   // Register reset values and register selects (address bit 2).
   localparam logic [31:0] BASE_INC_RESET = 32'd39370534;
   localparam logic [6:0]  HCOUNT_RESET   = 7'd8;
   localparam logic        REG_BASE_INC   = 1'b0;
   localparam logic        REG_HCOUNT     = 1'b1;

   typedef enum logic [1:0] {
      CMD_TICK       = 2'd0,
      CMD_LOAD_AMP   = 2'd1,
      CMD_LOAD_RATIO = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_RUN,
      BK_DRAIN,
      BK_FINISH
   } back_state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [5:0]  harmonic_index;
      logic [23:0] load_value;
   } aho_req_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               clipped;
   } aho_rsp_type;

   // One classified entry of the command queue.
   typedef struct packed {
      cmd_type     cmd;
      logic [5:0]  idx;
      logic [23:0] value;
   } aho_cmd_type;

   typedef logic signed [15:0] quarter_table_type [QUARTER_SIZE + 1];

   // round(32767 * sin(pi/2 * k / QUARTER_SIZE)) by a fixed-point Taylor series
   // in Q30, evaluated at elaboration.
   function automatic quarter_table_type build_quarter_table();
      quarter_table_type tbl;
      longint x;
      longint x2;
      longint term;
      longint sum;
      longint v;
      for (int k = 0; k <= QUARTER_SIZE; k++) begin
         x    = (PI_Q30 * longint'(k)) / (2 * QUARTER_SIZE);
         x2   = (x * x) >>> 30;
         term = x;
         sum  = x;
         term = ((term * x2) >>> 30) / 6;
         sum  = sum - term;
         term = ((term * x2) >>> 30) / 20;
         sum  = sum + term;
         term = ((term * x2) >>> 30) / 42;
         sum  = sum - term;
         term = ((term * x2) >>> 30) / 72;
         sum  = sum + term;
         term = ((term * x2) >>> 30) / 110;
         sum  = sum - term;
         term = ((term * x2) >>> 30) / 156;
         sum  = sum + term;
         if (sum < 0) begin
            sum = 0;
         end
         v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
         if (v > 32767) begin
            v = 32767;
         end
         tbl[k] = 16'(v);
      end
      return tbl;
   endfunction

   localparam quarter_table_type QUARTER_SINE = build_quarter_table();

endpackage

`default_nettype wire

@@ src/aho_ram.sv @@
`default_nettype none

module aho_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/aho_sine_rom.sv @@
`default_nettype none

module aho_sine_rom
   import aho_pkg::*;
(
   input  wire logic               clock,
   input  wire logic [SINE_AW-1:0] addr,
   output logic signed [15:0]      data
);

   logic [1:0]            quadrant;
   logic [SINE_AW-3:0]    offset;
   logic [QUARTER_AW-1:0] qidx;
   logic signed [15:0]    value;
   logic signed [15:0]    data_ff;

   always_comb begin
      quadrant = addr[SINE_AW-1:SINE_AW-2];
      offset   = addr[SINE_AW-3:0];
      // Odd quadrants run the quarter table backwards.
      if (quadrant[0]) begin
         qidx = QUARTER_AW'(QUARTER_SIZE) - QUARTER_AW'(offset);
      end else begin
         qidx = QUARTER_AW'(offset);
      end
      value = QUARTER_SINE[qidx];
   end

   always_ff @(posedge clock) begin
      data_ff <= quadrant[1] ? -value : value;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

@@ src/aho_front.sv @@
`default_nettype none

module aho_front
   import aho_pkg::*;
#(
   parameter int MAX_HARMONICS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire aho_req_type req_item,
   output aho_cmd_type      head,
   output logic             head_valid,
   input  wire logic        head_pop
);

   aho_cmd_type      entries_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff;
   logic [QAW-1:0]   wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff;
   logic [QAW-1:0]   rd_ptr_in;
   logic [QCW-1:0]   count_ff;
   logic [QCW-1:0]   count_in;
   logic             enq;
   logic             deq;
   logic             cmd_ok;
   aho_cmd_type      item;

   always_comb begin
      item.cmd   = cmd_type'(req_item.command);
      item.idx   = req_item.harmonic_index;
      item.value = req_item.load_value;
      // Unused commands and loads aimed past the stores are dropped here.
      case (req_item.command)
         CMD_TICK: begin
            cmd_ok = 1'b1;
         end
         CMD_LOAD_AMP, CMD_LOAD_RATIO: begin
            cmd_ok = 32'(req_item.harmonic_index) < MAX_HARMONICS;
         end
         default: begin
            cmd_ok = 1'b0;
         end
      endcase
      full      = count_ff == QCW'(QDEPTH);
      enq       = push && !full && cmd_ok;
      deq       = head_pop && (count_ff != '0);
      wr_ptr_in = enq ? wr_ptr_ff + QAW'(1) : wr_ptr_ff;
      rd_ptr_in = deq ? rd_ptr_ff + QAW'(1) : rd_ptr_ff;
      count_in  = count_ff + QCW'(enq) - QCW'(deq);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         entries_ff[wr_ptr_ff] <= item;
      end
   end

   assign head       = entries_ff[rd_ptr_ff];
   assign head_valid = count_ff != '0;

endmodule

`default_nettype wire

@@ src/aho_back.sv @@
`default_nettype none

module aho_back
   import aho_pkg::*;
#(
   parameter int MAX_HARMONICS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [31:0] base_inc,
   input  wire logic [6:0]  hcount,
   input  wire aho_cmd_type head,
   input  wire logic        head_valid,
   output logic             head_pop,
   input  wire logic        rsp_pop,
   output aho_rsp_type      rsp_item,
   output logic             rsp_valid
);

   localparam int AW    = (MAX_HARMONICS > 1) ? $clog2(MAX_HARMONICS) : 1;
   localparam int CW    = $clog2(MAX_HARMONICS + 1);
   localparam int ACC_W = 33 + CW;
   localparam int RW    = ACC_W - 16;
   localparam logic signed [RW-1:0] SAT_HI = RW'(32767);
   localparam logic signed [RW-1:0] SAT_LO = RW'(-32768);

   back_state_type state_ff;
   back_state_type state_in;
   logic [CW-1:0]  h_ff;
   logic [CW-1:0]  h_in;
   logic [CW-1:0]  count_ff;
   logic [CW-1:0]  count_in;
   logic [CW-1:0]  count_sat;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic [31:0]    phase_ff;
   logic [31:0]    phase_in;
   aho_rsp_type    rsp_ff;
   aho_rsp_type    rsp_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;

   logic [MAX_HARMONICS-1:0] rvalid_ff;
   logic [MAX_HARMONICS-1:0] avalid_ff;
   logic           issue;
   logic           amp_we;
   logic           ratio_we;
   logic [AW-1:0]  wr_addr;
   logic [AW-1:0]  rd_addr;
   logic [23:0]    ratio_rd;
   logic [15:0]    amp_rd;

   // Harmonic pipeline: store read, phase multiply, sine lookup, weight, sum.
   logic                s1_vld_ff;
   logic                s1_rv_ff;
   logic                s1_av_ff;
   logic                s2_vld_ff;
   logic [SINE_AW-1:0]  s2_idx_ff;
   logic [15:0]         s2_amp_ff;
   logic                s3_vld_ff;
   logic [15:0]         s3_amp_ff;
   logic                s4_vld_ff;
   logic signed [32:0]  term_ff;
   logic [55:0]         prod_in;
   logic signed [32:0]  term_in;
   logic signed [15:0]  rom_data;

   logic signed [ACC_W-1:0] rnd;
   logic signed [RW-1:0]    rsum;
   aho_rsp_type             result;

   assign wr_addr = AW'(head.idx);
   assign rd_addr = h_ff[AW-1:0];

   aho_ram #(.WIDTH(24), .DEPTH(MAX_HARMONICS)) u_ratio_ram (
      .clock   (clock),
      .wr_en   (ratio_we),
      .wr_addr (wr_addr),
      .wr_data (head.value),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (ratio_rd)
   );

   aho_ram #(.WIDTH(16), .DEPTH(MAX_HARMONICS)) u_amp_ram (
      .clock   (clock),
      .wr_en   (amp_we),
      .wr_addr (wr_addr),
      .wr_data (head.value[15:0]),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (amp_rd)
   );

   aho_sine_rom u_sine_rom (
      .clock (clock),
      .addr  (s2_idx_ff),
      .data  (rom_data)
   );

   always_comb begin
      prod_in = 56'(phase_ff) * 56'(s1_rv_ff ? ratio_rd : 24'd0);
      term_in = rom_data * $signed({1'b0, s3_amp_ff});
   end

   always_ff @(posedge clock) begin
      s1_rv_ff  <= rvalid_ff[rd_addr];
      s1_av_ff  <= avalid_ff[rd_addr];
      s2_idx_ff <= prod_in[FRAC_MSB -: SINE_AW];
      s2_amp_ff <= s1_av_ff ? amp_rd : 16'd0;
      s3_amp_ff <= s2_amp_ff;
      term_ff   <= term_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         rvalid_ff <= '0;
         avalid_ff <= '0;
      end else begin
         s1_vld_ff <= issue;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         if (ratio_we) begin
            rvalid_ff[wr_addr] <= 1'b1;
         end
         if (amp_we) begin
            avalid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Round half up to Q1.15, then saturate.
   always_comb begin
      rnd  = acc_ff + ACC_W'(32768);
      rsum = rnd[ACC_W-1:16];
      if (rsum > SAT_HI) begin
         result.sample  = 16'sh7FFF;
         result.clipped = 1'b1;
      end else if (rsum < SAT_LO) begin
         result.sample  = -16'sh8000;
         result.clipped = 1'b1;
      end else begin
         result.sample  = rsum[15:0];
         result.clipped = 1'b0;
      end
   end

   always_comb begin
      if (32'(hcount) > MAX_HARMONICS) begin
         count_sat = CW'(MAX_HARMONICS);
      end else begin
         count_sat = CW'(hcount);
      end
   end

   always_comb begin
      state_in     = state_ff;
      h_in         = h_ff;
      count_in     = count_ff;
      acc_in       = s4_vld_ff ? acc_ff + ACC_W'(term_ff) : acc_ff;
      phase_in     = phase_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      head_pop     = 1'b0;
      issue        = 1'b0;
      amp_we       = 1'b0;
      ratio_we     = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               case (head.cmd)
                  CMD_TICK: begin
                     acc_in   = '0;
                     h_in     = '0;
                     count_in = count_sat;
                     state_in = BK_RUN;
                  end
                  CMD_LOAD_AMP: begin
                     amp_we = 1'b1;
                  end
                  CMD_LOAD_RATIO: begin
                     ratio_we = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_RUN: begin
            if (h_ff < count_ff) begin
               issue = 1'b1;
               h_in  = h_ff + CW'(1);
            end else begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            if (!(s1_vld_ff || s2_vld_ff || s3_vld_ff || s4_vld_ff)) begin
               state_in = BK_FINISH;
            end
         end
         BK_FINISH: begin
            // The result register may still hold an earlier sample.
            if (!rsp_valid_ff || rsp_pop) begin
               rsp_in       = result;
               rsp_valid_in = 1'b1;
               phase_in     = phase_ff + base_inc;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff     <= h_in;
      count_ff <= count_in;
      acc_ff   <= acc_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_item  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

@@ src/additive_harmonic_oscillator_core.sv @@
`default_nettype none

// Additive oscillator: each tick transaction sums up to MAX_HARMONICS sine
// partials (ratio Q7.17 and amplitude Q0.16 per harmonic, loaded by load
// transactions) and returns one saturated Q1.15 sample, then advances the
// Q0.32 master phase by the phase step register. Load transactions are written
// to their store from the idle state of the execution unit. A tick holds it
// through the run, drain and finish states, with harmonic_count capped at
// MAX_HARMONICS. That time is set by the single multiply, sine lookup and
// accumulate pipeline that handles one harmonic per cycle, plus its fill and
// drain and the idle state that takes the next transaction. It is longer while
// an earlier sample waits to be popped. A four-entry command queue accepts new
// transactions while a tick runs, and a result register holds a finished
// sample until popped. Stores read as zero after reset; no clearing pass is
// needed.
module additive_harmonic_oscillator_core
   import aho_pkg::*;
#(
   parameter int MAX_HARMONICS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire aho_req_type req_item,
   output logic             empty,
   input  wire logic        pop,
   output aho_rsp_type      rsp_item,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [31:0]  base_inc_ff;
   logic [31:0]  base_inc_in;
   logic [6:0]   hcount_ff;
   logic [6:0]   hcount_in;
   logic         csr_write;
   aho_cmd_type  head;
   logic         head_valid;
   logic         head_pop;
   logic         rsp_valid;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      base_inc_in = base_inc_ff;
      hcount_in   = hcount_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_BASE_INC: begin
               base_inc_in = pwdata;
            end
            REG_HCOUNT: begin
               hcount_in = pwdata[6:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[1:0] == 2'b00) begin
         case (paddr[2])
            REG_BASE_INC: begin
               prdata = base_inc_ff;
            end
            REG_HCOUNT: begin
               prdata = 32'(hcount_ff);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_inc_ff <= BASE_INC_RESET;
         hcount_ff   <= HCOUNT_RESET;
      end else begin
         base_inc_ff <= base_inc_in;
         hcount_ff   <= hcount_in;
      end
   end

   aho_front #(.MAX_HARMONICS(MAX_HARMONICS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_item   (req_item),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop)
   );

   aho_back #(.MAX_HARMONICS(MAX_HARMONICS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .base_inc   (base_inc_ff),
      .hcount     (hcount_ff),
      .head       (head),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_pop    (pop),
      .rsp_item   (rsp_item),
      .rsp_valid  (rsp_valid)
   );

   assign empty = !rsp_valid;

endmodule

`default_nettype wire

@@ src/aho_checker.sv @@
`default_nettype none

module aho_checker
   import aho_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        full,
   input wire logic        empty,
   input wire logic        pop,
   input wire aho_rsp_type rsp_item,
   input wire logic        psel,
   input wire logic        penable,
   input wire logic        pwrite,
   input wire logic [2:0]  paddr,
   input wire logic [31:0] pwdata,
   input wire logic [31:0] prdata,
   input wire logic        pready
);

   // After reset, no result is pending and the command queue has room.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("result or queue state not cleared by reset");

   // A waiting result that is not popped stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_item)))
      else $error("pending result changed before it was popped");

   // A clipped sample sits at one of the two rails.
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_item.clipped) |->
      (rsp_item.sample == 16'sh7FFF || rsp_item.sample == -16'sh8000))
      else $error("clipped sample not at full scale");

   // The phase step register reads back what was just written.
   a_base_inc_readback: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready && paddr == {REG_BASE_INC, 2'b00}) ##1
      (psel && !pwrite && paddr == {REG_BASE_INC, 2'b00}) |-> prdata == $past(pwdata))
      else $error("phase step register readback mismatch");

endmodule

bind additive_harmonic_oscillator_core aho_checker u_aho_checker (.*);

`default_nettype wire
